// ===== src/ssba_pkg.sv =====
// Shared constants and codes for the scratch space block allocator.
package ssba_pkg;

  localparam int FREE_SLOTS_DEF  = 64;
  localparam int OFFSET_BITS_DEF = 40;
  localparam int SIZE_BITS_DEF   = 32;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_RESET = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_UNAVAIL   = 3'd2,
    ST_FULL      = 3'd3,
    ST_EXHAUSTED = 3'd4
  } status_t;

endpackage

// ===== src/scratch_space_block_allocator_unit.sv =====
// Scratch space block allocator: exact-fit free list with a bump end pointer.
//
// Free and reset transactions, and an allocate that finds the size zero or
// the space disabled, go straight to the result; an allocate that finds the
// list empty bumps the end pointer first. An allocate that scans the list
// reads one slot per cycle from the free-list memory, comparing each listed
// slot in turn; on a match it reads the last entry and writes it into the
// emptied slot, else it bumps the end pointer, then gives the result. The
// input is stalled while a transaction is in progress; one finished result
// may wait in the output register while the next transaction is taken.
// Free-list slots at or above the count are never compared and have no reset.
module scratch_space_block_allocator_unit #(
  parameter int FREE_SLOTS  = ssba_pkg::FREE_SLOTS_DEF,
  parameter int OFFSET_BITS = ssba_pkg::OFFSET_BITS_DEF,
  parameter int SIZE_BITS   = ssba_pkg::SIZE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_scratch_enabled,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_kind,
  input  logic [SIZE_BITS-1:0]              in_block_size,
  input  logic [OFFSET_BITS-1:0]            in_block_offset,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_status,
  output logic [OFFSET_BITS-1:0]            out_granted_offset,
  output logic                              out_recycled,
  output logic [OFFSET_BITS-1:0]            out_swapped_total,
  output logic [OFFSET_BITS-1:0]            out_space_end,
  output logic [$clog2(FREE_SLOTS+1)-1:0]   out_free_count
);
  import ssba_pkg::*;

  localparam int CW = $clog2(FREE_SLOTS + 1);
  localparam int AW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int SW = ((OFFSET_BITS > SIZE_BITS) ? OFFSET_BITS : SIZE_BITS) + 1;
  localparam logic [SW-1:0] OFF_MAX = SW'({OFFSET_BITS{1'b1}});
  localparam logic [CW-1:0] SLOTS   = CW'(FREE_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_BUMP,
    S_MVRD,
    S_MOVE,
    S_FIN
  } state_t;

  state_t                 state_r;
  logic                   en_r;
  logic [SIZE_BITS-1:0]   size_r;
  logic [AW-1:0]          scan_r;
  logic [CW-1:0]          cnt_r;
  logic [OFFSET_BITS-1:0] end_r;
  logic [OFFSET_BITS-1:0] sw_r;
  status_t                st_r;
  logic [OFFSET_BITS-1:0] grant_r;
  logic                   recyc_r;

  logic                   out_valid_r;
  logic [2:0]             out_status_r;
  logic [OFFSET_BITS-1:0] out_grant_r;
  logic                   out_recyc_r;
  logic [OFFSET_BITS-1:0] out_sw_r;
  logic [OFFSET_BITS-1:0] out_end_r;
  logic [CW-1:0]          out_cnt_r;

  logic [SIZE_BITS-1:0]   sz_mem  [FREE_SLOTS];
  logic [OFFSET_BITS-1:0] off_mem [FREE_SLOTS];
  logic [SIZE_BITS-1:0]   rd_sz_r;
  logic [OFFSET_BITS-1:0] rd_off_r;

  logic                   in_acc;
  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  logic [AW-1:0]          mem_ra;
  logic [SIZE_BITS-1:0]   mem_wsz;
  logic [OFFSET_BITS-1:0] mem_woff;
  logic [AW-1:0]          last_idx;
  logic [SW-1:0]          sw_sum;
  logic [SW-1:0]          end_sum;
  logic [OFFSET_BITS-1:0] sw_add;
  logic [OFFSET_BITS-1:0] sw_sub;
  logic                   free_ok;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign last_idx  = AW'(cnt_r - CW'(1));
  assign sw_sum    = SW'(sw_r) + SW'(size_r);
  assign end_sum   = SW'(end_r) + SW'(size_r);
  assign sw_add    = (sw_sum > OFF_MAX) ? OFF_MAX[OFFSET_BITS-1:0] : sw_sum[OFFSET_BITS-1:0];
  assign sw_sub    = (SW'(in_block_size) > SW'(sw_r)) ? '0
                   : OFFSET_BITS'(SW'(sw_r) - SW'(in_block_size));
  assign free_ok   = in_acc && (kind_t'(in_kind) == KIND_FREE)
                   && (in_block_size != '0) && (cnt_r != SLOTS);

  always_comb begin
    mem_we   = 1'b0;
    mem_wa   = cnt_r[AW-1:0];
    mem_wsz  = in_block_size;
    mem_woff = in_block_offset;
    mem_ra   = '0;
    unique case (state_r)
      S_IDLE: mem_we = free_ok;
      S_SCAN: mem_ra = AW'(scan_r + AW'(1));
      S_MVRD: mem_ra = last_idx;
      S_MOVE: begin
        mem_we   = 1'b1;
        mem_wa   = scan_r;
        mem_wsz  = rd_sz_r;
        mem_woff = rd_off_r;
      end
      default: mem_ra = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sz_mem[mem_wa]  <= mem_wsz;
      off_mem[mem_wa] <= mem_woff;
    end
    rd_sz_r  <= sz_mem[mem_ra];
    rd_off_r <= off_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      en_r        <= 1'b1;
      cnt_r       <= '0;
      end_r       <= '0;
      sw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        en_r <= cfg_scratch_enabled;
      end
      if (out_valid_r && !out_stall && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            size_r  <= in_block_size;
            scan_r  <= '0;
            grant_r <= '0;
            recyc_r <= 1'b0;
            unique case (kind_t'(in_kind))
              KIND_ALLOC: begin
                if (in_block_size == '0) begin
                  st_r    <= ST_ZERO;
                  state_r <= S_FIN;
                end else if (!en_r) begin
                  st_r    <= ST_UNAVAIL;
                  state_r <= S_FIN;
                end else if (cnt_r == '0) begin
                  st_r    <= ST_OK;
                  state_r <= S_BUMP;
                end else begin
                  st_r    <= ST_OK;
                  state_r <= S_SCAN;
                end
              end
              KIND_FREE: begin
                state_r <= S_FIN;
                if (in_block_size == '0) begin
                  st_r <= ST_ZERO;
                end else if (cnt_r == SLOTS) begin
                  st_r <= ST_FULL;
                end else begin
                  st_r  <= ST_OK;
                  cnt_r <= cnt_r + CW'(1);
                  sw_r  <= sw_sub;
                end
              end
              KIND_RESET: begin
                st_r    <= ST_OK;
                state_r <= S_FIN;
                cnt_r   <= '0;
                end_r   <= '0;
                sw_r    <= '0;
              end
              KIND_NONE: begin
                st_r    <= ST_OK;
                state_r <= S_FIN;
              end
              default: begin
                st_r    <= ST_OK;
                state_r <= S_FIN;
              end
            endcase
          end
        end
        S_SCAN: begin
          priority if (rd_sz_r == size_r) begin
            grant_r <= rd_off_r;
            recyc_r <= 1'b1;
            state_r <= S_MVRD;
          end else if (scan_r == last_idx) begin
            state_r <= S_BUMP;
          end else begin
            scan_r <= AW'(scan_r + AW'(1));
          end
        end
        S_BUMP: begin
          if (end_sum > OFF_MAX) begin
            st_r <= ST_EXHAUSTED;
          end else begin
            grant_r <= end_r;
            end_r   <= end_sum[OFFSET_BITS-1:0];
            sw_r    <= sw_add;
          end
          state_r <= S_FIN;
        end
        S_MVRD: state_r <= S_MOVE;
        S_MOVE: begin
          cnt_r   <= cnt_r - CW'(1);
          sw_r    <= sw_add;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= st_r;
            out_grant_r  <= grant_r;
            out_recyc_r  <= recyc_r;
            out_sw_r     <= sw_r;
            out_end_r    <= end_r;
            out_cnt_r    <= cnt_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_offset = out_grant_r;
  assign out_recycled       = out_recyc_r;
  assign out_swapped_total  = out_sw_r;
  assign out_space_end      = out_end_r;
  assign out_free_count     = out_cnt_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SLOTS)
    else $error("free list count above capacity");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r != '0) && (CW'(scan_r) < cnt_r))
    else $error("scan beyond listed entries");

  a_recycled_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_recyc_r) |-> (out_status_r == ST_OK))
    else $error("recycled block with failing status");

  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_grant_r == '0) && !out_recyc_r)
    else $error("grant given on failed transaction");

  a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN) && (state_r == S_IDLE))
    else $error("result loaded outside finish step");

endmodule

// ===== test/ssba_grant_checker.sv =====
`timescale 1ns / 1ps
// Grant checker: tracks the free list and end pointer, predicts each result and compares it.
module ssba_grant_checker #(
  parameter int FREE_SLOTS  = ssba_pkg::FREE_SLOTS_DEF,
  parameter int OFFSET_BITS = ssba_pkg::OFFSET_BITS_DEF,
  parameter int SIZE_BITS   = ssba_pkg::SIZE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_scratch_enabled,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [1:0]                      in_kind,
  input  logic [SIZE_BITS-1:0]            in_block_size,
  input  logic [OFFSET_BITS-1:0]          in_block_offset,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [2:0]                      out_status,
  input  logic [OFFSET_BITS-1:0]          out_granted_offset,
  input  logic                            out_recycled,
  input  logic [OFFSET_BITS-1:0]          out_swapped_total,
  input  logic [OFFSET_BITS-1:0]          out_space_end,
  input  logic [$clog2(FREE_SLOTS+1)-1:0] out_free_count,
  output int                              grants_owed,
  output int                              mismatch_count
);
  import ssba_pkg::*;

  localparam int OW = OFFSET_BITS;
  localparam int SW = SIZE_BITS;
  localparam int CW = $clog2(FREE_SLOTS + 1);
  localparam logic [OW-1:0] OFF_TOP = '1;

  typedef struct packed {
    status_t       status;
    logic [OW-1:0] granted;
    logic          recycled;
    logic [OW-1:0] held;
    logic [OW-1:0] end_p;
    logic [CW-1:0] count;
  } grant_t;

  logic [OW-1:0] list_off  [FREE_SLOTS];
  logic [SW-1:0] list_size [FREE_SLOTS];
  int            list_len = 0;
  logic [OW-1:0] end_ptr  = '0;
  logic [OW-1:0] held     = '0;
  logic          enabled  = 1'b1;
  grant_t        grants_due [$];
  int            errs = 0;

  task automatic add_held(input logic [SW-1:0] sz);
    longint unsigned sum;
    sum  = 64'(held) + 64'(sz);
    held = (sum > 64'(OFF_TOP)) ? OFF_TOP : OW'(sum);
  endtask

  task automatic serve_request(input logic [1:0] k, input logic [SW-1:0] sz,
                               input logic [OW-1:0] off, output grant_t r);
    int hit;
    r = '0;
    r.status = ST_OK;
    case (kind_t'(k))
      KIND_ALLOC: begin
        if (sz == '0) begin
          r.status = ST_ZERO;
        end else if (!enabled) begin
          r.status = ST_UNAVAIL;
        end else begin
          hit = -1;
          for (int i = 0; i < list_len; i++) begin
            if (hit < 0 && list_size[i] == sz) hit = i;
          end
          if (hit >= 0) begin
            r.granted      = list_off[hit];
            r.recycled     = 1'b1;
            list_off[hit]  = list_off[list_len-1];
            list_size[hit] = list_size[list_len-1];
            list_len--;
            add_held(sz);
          end else if (OW'(sz) > OFF_TOP - end_ptr) begin
            r.status = ST_EXHAUSTED;
          end else begin
            r.granted = end_ptr;
            end_ptr   = end_ptr + OW'(sz);
            add_held(sz);
          end
        end
      end
      KIND_FREE: begin
        if (sz == '0) begin
          r.status = ST_ZERO;
        end else if (list_len >= FREE_SLOTS) begin
          r.status = ST_FULL;
        end else begin
          list_off[list_len]  = off;
          list_size[list_len] = sz;
          list_len++;
          held = (OW'(sz) > held) ? '0 : held - OW'(sz);
        end
      end
      KIND_RESET: begin
        list_len = 0;
        end_ptr  = '0;
        held     = '0;
      end
      default: ;
    endcase
    r.held  = held;
    r.end_p = end_ptr;
    r.count = CW'(list_len);
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    grant_t want, fresh;
    if (!rst_n) begin
      list_len = 0;
      end_ptr  = '0;
      held     = '0;
      enabled  = 1'b1;
      grants_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (grants_due.size() == 0) begin
          $error("result transaction with no request outstanding");
          errs++;
        end else begin
          want = grants_due.pop_front();
          check_field("status", 64'(want.status), 64'(out_status));
          check_field("granted_offset", 64'(want.granted), 64'(out_granted_offset));
          check_field("recycled", 64'(want.recycled), 64'(out_recycled));
          check_field("swapped_total", 64'(want.held), 64'(out_swapped_total));
          check_field("space_end", 64'(want.end_p), 64'(out_space_end));
          check_field("free_count", 64'(want.count), 64'(out_free_count));
        end
      end
      if (cfg_we) enabled = cfg_scratch_enabled;
      if (in_valid && !in_stall) begin
        serve_request(in_kind, in_block_size, in_block_offset, fresh);
        grants_due = {grants_due, fresh};
      end
    end
    grants_owed    <= grants_due.size();
    mismatch_count <= errs;
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top: drives requests and configuration into the allocator and reports the verdict.
module tb_top;
  import ssba_pkg::*;

  localparam int OW = OFFSET_BITS_DEF;
  localparam int SW = SIZE_BITS_DEF;
  localparam int CW = $clog2(FREE_SLOTS_DEF + 1);
  localparam logic [SW-1:0] SIZE_MAX = '1;
  localparam logic [OW-1:0] OFF_MAX  = '1;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          cfg_we = 1'b0;
  logic          cfg_scratch_enabled = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [1:0]    in_kind = KIND_ALLOC;
  logic [SW-1:0] in_block_size = '0;
  logic [OW-1:0] in_block_offset = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [2:0]    out_status;
  logic [OW-1:0] out_granted_offset;
  logic          out_recycled;
  logic [OW-1:0] out_swapped_total;
  logic [OW-1:0] out_space_end;
  logic [CW-1:0] out_free_count;

  int            grants_owed;
  int            mismatch_count;
  bit            no_idle = 1'b0;
  int            stall_left = 0;
  logic [SW-1:0] big_sizes [FREE_SLOTS_DEF];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  scratch_space_block_allocator_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_scratch_enabled (cfg_scratch_enabled),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_block_size       (in_block_size),
    .in_block_offset     (in_block_offset),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_granted_offset  (out_granted_offset),
    .out_recycled        (out_recycled),
    .out_swapped_total   (out_swapped_total),
    .out_space_end       (out_space_end),
    .out_free_count      (out_free_count)
  );

  ssba_grant_checker u_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_scratch_enabled (cfg_scratch_enabled),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_block_size       (in_block_size),
    .in_block_offset     (in_block_offset),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_granted_offset  (out_granted_offset),
    .out_recycled        (out_recycled),
    .out_swapped_total   (out_swapped_total),
    .out_space_end       (out_space_end),
    .out_free_count      (out_free_count),
    .grants_owed         (grants_owed),
    .mismatch_count      (mismatch_count)
  );

  // result side: fresh stall length drawn after every accepted result
  always @(posedge clk) begin
    int n;
    if (out_valid && !out_stall) begin
      n = no_idle ? 0 : $urandom_range(0, 15);
      stall_left <= n;
      out_stall  <= (n != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  task automatic push_request(input kind_t k, input logic [SW-1:0] sz, input logic [OW-1:0] off);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= k;
    in_block_size   <= sz;
    in_block_offset <= off;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (grants_owed != 0);
  endtask

  task automatic set_scratch(input logic en);
    cfg_we              <= 1'b1;
    cfg_scratch_enabled <= en;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [OW-1:0] rand_offset();
    return OW'({$urandom(), $urandom()});
  endfunction

  task automatic push_random();
    int            pick;
    kind_t         k;
    logic [SW-1:0] sz;
    pick = $urandom_range(0, 99);
    k = (pick < 48) ? KIND_ALLOC : (pick < 96) ? KIND_FREE :
        (pick < 98) ? KIND_RESET : KIND_NONE;
    case ($urandom_range(0, 19))
      0:       sz = '0;
      1, 2:    sz = $urandom();
      3, 4:    sz = SW'($urandom_range(1, 400));
      default: sz = SW'($urandom_range(1, 8));
    endcase
    push_request(k, sz, rand_offset());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    push_request(KIND_ALLOC, '0, '0);
    push_request(KIND_FREE, '0, rand_offset());
    push_request(KIND_ALLOC, SW'(1), '0);
    push_request(KIND_ALLOC, SIZE_MAX, '0);
    push_request(KIND_FREE, SIZE_MAX, OFF_MAX);
    push_request(KIND_ALLOC, SIZE_MAX, '0);
    push_request(KIND_FREE, SW'(5), '0);
    push_request(KIND_FREE, SW'(7), OW'(123));
    push_request(KIND_FREE, SW'(5), OW'(40'h55_5555_5555));
    push_request(KIND_ALLOC, SW'(5), '0);
    push_request(KIND_ALLOC, SW'(7), '0);
    push_request(KIND_ALLOC, SW'(5), '0);
    push_request(KIND_NONE, SIZE_MAX, OFF_MAX);
    push_request(KIND_FREE, SIZE_MAX, OW'(40'hAA_AAAA_AAAA));
    push_request(KIND_RESET, SIZE_MAX, OFF_MAX);
    push_request(KIND_ALLOC, SW'(9), '0);
    drain();
    set_scratch(1'b0);
    push_request(KIND_ALLOC, SW'(10), '0);
    push_request(KIND_ALLOC, '0, '0);
    push_request(KIND_FREE, SW'(10), OW'(1));
    push_request(KIND_ALLOC, SW'(10), '0);
    push_request(KIND_RESET, '0, '0);
    drain();
    set_scratch(1'b1);
    push_request(KIND_ALLOC, SW'(10), '0);

    // full list, recycling of large blocks, then bump until the space runs out
    drain();
    push_request(KIND_RESET, '0, '0);
    for (int i = 0; i < FREE_SLOTS_DEF; i++) begin
      big_sizes[i] = $urandom_range(32'hF000_0000, 32'hFFFF_FFFF);
      push_request(KIND_FREE, big_sizes[i], rand_offset());
    end
    push_request(KIND_FREE, SIZE_MAX, OFF_MAX);
    for (int i = FREE_SLOTS_DEF - 1; i >= 0; i--) begin
      push_request(KIND_ALLOC, big_sizes[i], rand_offset());
    end
    for (int i = 0; i < 258; i++) begin
      push_request(KIND_ALLOC, SIZE_MAX, rand_offset());
    end
    push_request(KIND_ALLOC, SW'(255), '0);
    push_request(KIND_ALLOC, SW'(1), '0);
    push_request(KIND_RESET, '0, '0);

    for (int p = 0; p < 10; p++) begin
      drain();
      if (p == 3 || p == 7) set_scratch(1'b0);
      else if (p == 9) set_scratch(1'b1);
      else set_scratch($urandom_range(0, 3) != 0);
      no_idle = (p % 3 == 1);
      repeat (105) push_random();
    end

    drain();
    no_idle = 1'b0;
    repeat (FREE_SLOTS_DEF + 6) @(posedge clk);
    if (mismatch_count == 0 && grants_owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
